@@ rtl/pvs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pvs_pkg;

    // Field widths.
    localparam int DIST_WIDTH      = 24;
    localparam int SCALE_FRAC_BITS = 16;
    localparam int SCALE_WIDTH     = SCALE_FRAC_BITS + 1;

    // Internal fixed point: fractions carry 30 bits.
    localparam int FRAC       = 30;
    localparam int Q_BITS     = FRAC + 1;
    localparam int NUM_WIDTH  = DIST_WIDTH + FRAC;
    localparam logic [Q_BITS-1:0] ONE_Q30 = Q_BITS'(1) << FRAC;

    // ln(1000) in Q.30, split for two narrow partial products.
    localparam int LN_WIDTH    = 33;
    localparam int LN_LO_BITS  = 16;
    localparam int PROD_WIDTH  = Q_BITS + LN_WIDTH;
    localparam logic [LN_WIDTH-1:0] LN1000_Q30 = 33'd7417145753;
    localparam logic [LN_WIDTH-LN_LO_BITS-1:0] LN_HI = LN1000_Q30[LN_WIDTH-1:LN_LO_BITS];
    localparam logic [LN_LO_BITS-1:0] LN_LO = LN1000_Q30[LN_LO_BITS-1:0];
    localparam logic [PROD_WIDTH-1:0] HALF_Q30 = PROD_WIDTH'(1) << (FRAC - 1);

    // ln(2) in Q.30 and the range of the power-of-two count.
    localparam logic [FRAC-1:0] LN2_Q30 = 30'd744261118;
    localparam int EXP_MAX = 9;
    localparam int N_WIDTH = 4;

    // Horner series for exp(-y): term j divides by 12 - j.
    localparam int SERIES_TERMS = 12;
    localparam int K_WIDTH      = 4;
    localparam longint unsigned ONE_VAL = 64'd1 << FRAC;
    localparam logic [K_WIDTH-1:0] TERM_DIVISOR [SERIES_TERMS] = '{
        4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1
    };
    localparam logic [Q_BITS-1:0] RECIP_Q30 [SERIES_TERMS] = '{
        Q_BITS'(ONE_VAL / 12), Q_BITS'(ONE_VAL / 11), Q_BITS'(ONE_VAL / 10),
        Q_BITS'(ONE_VAL / 9),  Q_BITS'(ONE_VAL / 8),  Q_BITS'(ONE_VAL / 7),
        Q_BITS'(ONE_VAL / 6),  Q_BITS'(ONE_VAL / 5),  Q_BITS'(ONE_VAL / 4),
        Q_BITS'(ONE_VAL / 3),  Q_BITS'(ONE_VAL / 2),  Q_BITS'(ONE_VAL / 1)
    };

    // Final rounding shift.
    localparam int SHIFT_BASE  = FRAC - SCALE_FRAC_BITS;
    localparam int SH_WIDTH    = $clog2(SHIFT_BASE + EXP_MAX + 1);
    localparam int ROUND_WIDTH = FRAC + 2;
    localparam logic [SCALE_WIDTH-1:0] FULL_SCALE = SCALE_WIDTH'(1) << SCALE_FRAC_BITS;

    // Pipeline stage numbers inside one lane.
    localparam int ST_PREP      = 0;
    localparam int ST_NUM       = 1;
    localparam int ST_MUL       = ST_NUM + Q_BITS + 1;
    localparam int ST_Z         = ST_MUL + 1;
    localparam int ST_CMP       = ST_Z + 1;
    localparam int ST_RED       = ST_CMP + 1;
    localparam int SER_STAGES   = 3 * SERIES_TERMS;
    localparam int ST_FIN       = ST_RED + SER_STAGES + 1;
    localparam int LANE_STAGES  = ST_FIN + 1;
    localparam int TOTAL_STAGES = LANE_STAGES + 1;

    // Configuration registers.
    localparam int CFG_INDEX_WIDTH = 2;
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_CHECK_ENABLE    = 2'd0,
        CFG_SELF_THRESHOLD  = 2'd1,
        CFG_SCENE_THRESHOLD = 2'd2
    } t_cfg_reg;

    localparam logic                  CHECK_ENABLE_RESET    = 1'b1;
    localparam logic [DIST_WIDTH-1:0] SELF_THRESHOLD_RESET  = DIST_WIDTH'(6554);
    localparam logic [DIST_WIDTH-1:0] SCENE_THRESHOLD_RESET = DIST_WIDTH'(13107);

    // Overrides that travel beside the lanes.
    typedef struct packed {
        logic full;
        logic zero;
    } t_side;

    // Multiple of ln(2) in Q.30 for a small count.
    function automatic logic [LN_WIDTH-1:0] ln2_multiple(input logic [N_WIDTH-1:0] n);
        return LN_WIDTH'(n) * LN_WIDTH'(LN2_Q30);
    endfunction

endpackage

`default_nettype wire

@@ rtl/pvs_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pvs_lane (
    input  wire logic                               i_clk,
    input  wire logic [pvs_pkg::LANE_STAGES-1:0]     i_move,
    input  wire logic [pvs_pkg::DIST_WIDTH-1:0]      i_distance,
    input  wire logic [pvs_pkg::DIST_WIDTH-1:0]      i_threshold,
    output logic      [pvs_pkg::SCALE_WIDTH-1:0]     o_scale
);
    import pvs_pkg::*;

    localparam int Y_DEPTH = SER_STAGES - 3;

    // Threshold fix-up, compare and difference.
    logic [DIST_WIDTH-1:0] n_prep_th;
    logic [DIST_WIDTH-1:0] r_prep_th;
    logic [DIST_WIDTH-1:0] r_prep_delta;
    logic                  r_prep_full;

    assign n_prep_th = (i_threshold == '0) ? DIST_WIDTH'(1) : i_threshold;

    always_ff @(posedge i_clk) begin
        if (i_move[ST_PREP]) begin
            r_prep_th    <= n_prep_th;
            r_prep_full  <= (i_distance >= n_prep_th);
            r_prep_delta <= n_prep_th - i_distance;
        end
    end

    // Rounded numerator for the ratio; its top bits seed the divider.
    logic [NUM_WIDTH-1:0] num_sum;

    assign num_sum = {r_prep_delta, {FRAC{1'b0}}} + NUM_WIDTH'(r_prep_th >> 1);

    // Restoring divider, one quotient bit per stage. Entry 0 is the seed.
    logic [DIST_WIDTH-1:0] r_dv_rem  [Q_BITS];
    logic [DIST_WIDTH-1:0] r_dv_th   [Q_BITS];
    logic [Q_BITS-1:0]     r_dv_rq   [Q_BITS+1];
    logic                  r_dv_full [Q_BITS+1];
    logic [DIST_WIDTH:0]   dv_trial  [Q_BITS];
    logic [DIST_WIDTH:0]   dv_diff   [Q_BITS];
    logic                  dv_ge     [Q_BITS];

    always_comb begin
        for (int j = 0; j < Q_BITS; j++) begin
            dv_trial[j] = {r_dv_rem[j], r_dv_rq[j][Q_BITS-1]};
            dv_ge[j]    = (dv_trial[j] >= {1'b0, r_dv_th[j]});
            dv_diff[j]  = dv_trial[j] - {1'b0, r_dv_th[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_move[ST_NUM]) begin
            r_dv_rem[0]  <= DIST_WIDTH'(num_sum[NUM_WIDTH-1:Q_BITS]);
            r_dv_rq[0]   <= num_sum[Q_BITS-1:0];
            r_dv_th[0]   <= r_prep_th;
            r_dv_full[0] <= r_prep_full;
        end
        for (int j = 1; j <= Q_BITS; j++) begin
            if (i_move[ST_NUM + j]) begin
                r_dv_rq[j]   <= {r_dv_rq[j-1][Q_BITS-2:0], dv_ge[j-1]};
                r_dv_full[j] <= r_dv_full[j-1];
                if (j < Q_BITS) begin
                    r_dv_rem[j] <= dv_ge[j-1] ? dv_diff[j-1][DIST_WIDTH-1:0]
                                              : dv_trial[j-1][DIST_WIDTH-1:0];
                    r_dv_th[j]  <= r_dv_th[j-1];
                end
            end
        end
    end

    // Ratio times ln(1000) as two partial products.
    logic [Q_BITS+LN_WIDTH-LN_LO_BITS-1:0] r_mul_hi;
    logic [Q_BITS+LN_LO_BITS-1:0]          r_mul_lo;
    logic                                  r_mul_full;

    always_ff @(posedge i_clk) begin
        if (i_move[ST_MUL]) begin
            r_mul_hi   <= (Q_BITS+LN_WIDTH-LN_LO_BITS)'(r_dv_rq[Q_BITS])
                        * (Q_BITS+LN_WIDTH-LN_LO_BITS)'(LN_HI);
            r_mul_lo   <= (Q_BITS+LN_LO_BITS)'(r_dv_rq[Q_BITS])
                        * (Q_BITS+LN_LO_BITS)'(LN_LO);
            r_mul_full <= r_dv_full[Q_BITS];
        end
    end

    // Sum the partial products and round to Q.30.
    logic [PROD_WIDTH-1:0] z_sum;
    logic [LN_WIDTH-1:0]   r_z_z;
    logic                  r_z_full;

    assign z_sum = {r_mul_hi, {LN_LO_BITS{1'b0}}} + PROD_WIDTH'(r_mul_lo) + HALF_Q30;

    always_ff @(posedge i_clk) begin
        if (i_move[ST_Z]) begin
            r_z_z    <= z_sum[FRAC+LN_WIDTH-1:FRAC];
            r_z_full <= r_mul_full;
        end
    end

    // Count how many whole ln(2) steps fit in the exponent.
    logic [N_WIDTH-1:0]  cmp_n;
    logic [LN_WIDTH-1:0] r_cmp_z;
    logic [N_WIDTH-1:0]  r_cmp_n;
    logic                r_cmp_full;

    always_comb begin
        cmp_n = '0;
        for (int k = 1; k <= EXP_MAX; k++) begin
            if (r_z_z >= ln2_multiple(N_WIDTH'(k))) begin
                cmp_n = cmp_n + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_move[ST_CMP]) begin
            r_cmp_z    <= r_z_z;
            r_cmp_n    <= cmp_n;
            r_cmp_full <= r_z_full;
        end
    end

    // Remainder after the ln(2) steps, then the Horner series.
    logic [LN_WIDTH-1:0] red_y;
    logic [FRAC-1:0]     r_sr_y    [Y_DEPTH+1];
    logic [N_WIDTH-1:0]  r_sr_n    [SER_STAGES+1];
    logic                r_sr_full [SER_STAGES+1];
    logic [FRAC-1:0]     r_sa_p    [SERIES_TERMS];
    logic [FRAC-1:0]     r_sb_q    [SERIES_TERMS];
    logic [FRAC-1:0]     r_sb_p    [SERIES_TERMS];
    logic [Q_BITS-1:0]   r_sc_t    [SERIES_TERMS];

    logic [Q_BITS-1:0]        sr_t_in [SERIES_TERMS];
    logic [FRAC+Q_BITS-1:0]   sa_prod [SERIES_TERMS];
    logic [FRAC+Q_BITS-1:0]   sb_prod [SERIES_TERMS];
    logic [FRAC+K_WIDTH-1:0]  sc_mul  [SERIES_TERMS];
    logic [FRAC+K_WIDTH-1:0]  sc_rem  [SERIES_TERMS];
    logic [Q_BITS-1:0]        sc_t    [SERIES_TERMS];

    assign red_y = r_cmp_z - ln2_multiple(r_cmp_n);

    // Each term: multiply by y, divide by a small constant through its
    // reciprocal, then correct the estimate by at most one.
    always_comb begin
        sr_t_in[0] = ONE_Q30;
        for (int j = 1; j < SERIES_TERMS; j++) begin
            sr_t_in[j] = r_sc_t[j-1];
        end
        for (int j = 0; j < SERIES_TERMS; j++) begin
            sa_prod[j] = (FRAC+Q_BITS)'(r_sr_y[3*j]) * (FRAC+Q_BITS)'(sr_t_in[j]);
            sb_prod[j] = (FRAC+Q_BITS)'(r_sa_p[j]) * (FRAC+Q_BITS)'(RECIP_Q30[j]);
            sc_mul[j]  = (FRAC+K_WIDTH)'(r_sb_q[j]) * (FRAC+K_WIDTH)'(TERM_DIVISOR[j]);
            sc_rem[j]  = (FRAC+K_WIDTH)'(r_sb_p[j]) - sc_mul[j];
            sc_t[j]    = ONE_Q30 - Q_BITS'(r_sb_q[j])
                       - Q_BITS'(sc_rem[j] >= (FRAC+K_WIDTH)'(TERM_DIVISOR[j]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_move[ST_RED]) begin
            r_sr_y[0]    <= red_y[FRAC-1:0];
            r_sr_n[0]    <= r_cmp_n;
            r_sr_full[0] <= r_cmp_full;
        end
        for (int m = 1; m <= SER_STAGES; m++) begin
            if (i_move[ST_RED + m]) begin
                r_sr_n[m]    <= r_sr_n[m-1];
                r_sr_full[m] <= r_sr_full[m-1];
                if (m <= Y_DEPTH) begin
                    r_sr_y[m] <= r_sr_y[m-1];
                end
            end
        end
        for (int j = 0; j < SERIES_TERMS; j++) begin
            if (i_move[ST_RED + 3*j + 1]) begin
                r_sa_p[j] <= sa_prod[j][2*FRAC-1:FRAC];
            end
            if (i_move[ST_RED + 3*j + 2]) begin
                r_sb_q[j] <= sb_prod[j][2*FRAC-1:FRAC];
                r_sb_p[j] <= r_sa_p[j];
            end
            if (i_move[ST_RED + 3*j + 3]) begin
                r_sc_t[j] <= sc_t[j];
            end
        end
    end

    // Scale by 2^-n and round to the output format.
    logic [SH_WIDTH-1:0]    fin_sh;
    logic [ROUND_WIDTH-1:0] fin_sum;
    logic [ROUND_WIDTH-1:0] fin_shifted;
    logic [SCALE_WIDTH-1:0] r_fin_scale;

    always_comb begin
        fin_sh      = SH_WIDTH'(SHIFT_BASE) + SH_WIDTH'(r_sr_n[SER_STAGES]);
        fin_sum     = ROUND_WIDTH'(r_sc_t[SERIES_TERMS-1])
                    + (ROUND_WIDTH'(1) << (fin_sh - 1'b1));
        fin_shifted = fin_sum >> fin_sh;
    end

    always_ff @(posedge i_clk) begin
        if (i_move[ST_FIN]) begin
            r_fin_scale <= r_sr_full[SER_STAGES] ? FULL_SCALE
                                                 : fin_shifted[SCALE_WIDTH-1:0];
        end
    end

    assign o_scale = r_fin_scale;

endmodule

`default_nettype wire

@@ rtl/proximity_velocity_scaler.sv @@
// Throughput: one item per cycle while the output is not stalled. The depth comes
// from a 31-step restoring divider and a 12-term exp series (three stages per term)
// in each lane.
// On an output stall empty stages still fill, so o_ready drops only when stage 0 holds an item.
// Reset (synchronous, active low) empties the pipeline and loads check_enable = 1,
// self_threshold = 6554 and scene_threshold = 13107.
`timescale 1ns / 1ps
`default_nettype none

module proximity_velocity_scaler (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic                                  i_self_hit,
    input  wire logic                                  i_scene_hit,
    input  wire logic [pvs_pkg::DIST_WIDTH-1:0]         i_self_distance,
    input  wire logic [pvs_pkg::DIST_WIDTH-1:0]         i_scene_distance,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic      [pvs_pkg::SCALE_WIDTH-1:0]        o_velocity_scale,
    input  wire logic                                  i_cfg_we,
    input  wire logic [pvs_pkg::CFG_INDEX_WIDTH-1:0]    i_cfg_index,
    input  wire logic [pvs_pkg::DIST_WIDTH-1:0]         i_cfg_data
);
    import pvs_pkg::*;

    // Configuration registers.
    logic                  r_check_enable;
    logic [DIST_WIDTH-1:0] r_self_thr;
    logic [DIST_WIDTH-1:0] r_scene_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_enable <= CHECK_ENABLE_RESET;
            r_self_thr     <= SELF_THRESHOLD_RESET;
            r_scene_thr    <= SCENE_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHECK_ENABLE: begin
                    r_check_enable <= i_cfg_data[0];
                end
                CFG_SELF_THRESHOLD: begin
                    r_self_thr <= i_cfg_data;
                end
                CFG_SCENE_THRESHOLD: begin
                    r_scene_thr <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Stage control: everything shifts when the output is free; otherwise
    // an empty stage still pulls in the item above it.
    logic                    adv;
    logic [TOTAL_STAGES-1:0] move;
    logic [TOTAL_STAGES-1:0] r_valid;
    logic [TOTAL_STAGES-1:0] n_valid;

    assign adv = !r_valid[TOTAL_STAGES-1] || i_ready;

    always_comb begin
        for (int s = 0; s < TOTAL_STAGES; s++) begin
            move[s] = adv || !r_valid[s];
        end
        n_valid[0] = move[0] ? i_valid : (r_valid[0] && !move[1]);
        for (int s = 1; s < TOTAL_STAGES - 1; s++) begin
            n_valid[s] = move[s] ? r_valid[s-1] : (r_valid[s] && !move[s+1]);
        end
        n_valid[TOTAL_STAGES-1] = move[TOTAL_STAGES-1] ? r_valid[TOTAL_STAGES-2]
                                                       : r_valid[TOTAL_STAGES-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ready = move[0];

    // Overrides for disabled checking and hit flags ride beside the lanes.
    t_side r_side [LANE_STAGES];

    always_ff @(posedge i_clk) begin
        if (move[0]) begin
            r_side[0].full <= !r_check_enable;
            r_side[0].zero <= i_self_hit || i_scene_hit;
        end
        for (int s = 1; s < LANE_STAGES; s++) begin
            if (move[s]) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // The two proximity lanes.
    logic [SCALE_WIDTH-1:0] self_scale;
    logic [SCALE_WIDTH-1:0] scene_scale;

    pvs_lane u_self_lane (
        .i_clk       (i_clk),
        .i_move      (move[LANE_STAGES-1:0]),
        .i_distance  (i_self_distance),
        .i_threshold (r_self_thr),
        .o_scale     (self_scale)
    );

    pvs_lane u_scene_lane (
        .i_clk       (i_clk),
        .i_move      (move[LANE_STAGES-1:0]),
        .i_distance  (i_scene_distance),
        .i_threshold (r_scene_thr),
        .o_scale     (scene_scale)
    );

    // Output register: overrides first, then the smaller lane scale.
    logic [SCALE_WIDTH-1:0] n_out_scale;
    logic [SCALE_WIDTH-1:0] r_out_scale;

    always_comb begin
        if (r_side[LANE_STAGES-1].full) begin
            n_out_scale = FULL_SCALE;
        end else if (r_side[LANE_STAGES-1].zero) begin
            n_out_scale = '0;
        end else if (self_scale < scene_scale) begin
            n_out_scale = self_scale;
        end else begin
            n_out_scale = scene_scale;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move[LANE_STAGES]) begin
            r_out_scale <= n_out_scale;
        end
    end

    assign o_valid          = r_valid[TOTAL_STAGES-1];
    assign o_velocity_scale = r_out_scale;

    // A delivered scale never exceeds 1.0.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_velocity_scale <= FULL_SCALE))
        else $error("velocity scale above full scale");

    // Items in flight change only by accepts and deliveries.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> ($countones(r_valid) == $past($countones(r_valid))
                     + $past(i_valid && o_ready) - $past(o_valid && i_ready)))
        else $error("item lost or duplicated in the pipeline");

    // A full pipeline with a stalled output takes no new item.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_valid) && !i_ready) |-> !o_ready)
        else $error("item accepted into a full stalled pipeline");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import pvs_pkg::*;

    // Fixed-point constants of the scale computation in Q.30, and the series length.
    localparam longint unsigned UNITY_FIX  = 64'd1 << 30;
    localparam longint unsigned LN1000_FIX = 64'd7417145753;
    localparam longint unsigned LN2_FIX    = 64'd744261118;
    localparam int              EXP_TERMS  = 12;

    // Index that decodes to no register.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INDEX_UNUSED = 2'd3;

    localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};

    typedef struct {
        logic                  self_hit;
        logic                  scene_hit;
        logic [DIST_WIDTH-1:0] self_dist;
        logic [DIST_WIDTH-1:0] scene_dist;
    } t_report;

    // Clock, reset and block ports.
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic                       i_self_hit = 1'b0;
    logic                       i_scene_hit = 1'b0;
    logic [DIST_WIDTH-1:0]      i_self_distance = '0;
    logic [DIST_WIDTH-1:0]      i_scene_distance = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [SCALE_WIDTH-1:0]     o_velocity_scale;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = CFG_CHECK_ENABLE;
    logic [DIST_WIDTH-1:0]      i_cfg_data = '0;

    // Shadow copy of the configuration registers.
    logic                  cfg_check_enable = CHECK_ENABLE_RESET;
    logic [DIST_WIDTH-1:0] cfg_self_thr = SELF_THRESHOLD_RESET;
    logic [DIST_WIDTH-1:0] cfg_scene_thr = SCENE_THRESHOLD_RESET;

    // Reports waiting to be driven and scales waiting to come out.
    t_report                pending_reports[$];
    logic [SCALE_WIDTH-1:0] expected_scales[$];
    t_report                driven_report;

    // Idle control shared by the stimulus, the driver and the monitor.
    bit send_idle_on = 1'b0;
    bit recv_idle_on = 1'b0;
    int send_wait = 0;
    int recv_wait = 0;
    int long_hold_cycles = 0;

    int reports_sent = 0;
    int scales_checked = 0;
    int mismatch_count = 0;
    int reg_writes = 0;

    proximity_velocity_scaler DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_self_hit       (i_self_hit),
        .i_scene_hit      (i_scene_hit),
        .i_self_distance  (i_self_distance),
        .i_scene_distance (i_scene_distance),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_velocity_scale (o_velocity_scale),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // The clock runs with a 20 ns period.
    always #10 i_clk = ~i_clk;

    // Scale for one distance against its threshold: 1000^(-(thr - d) / thr) in Q1.16.
    function automatic longint unsigned proximity_term(input logic [DIST_WIDTH-1:0] dist_in,
                                                       input logic [DIST_WIDTH-1:0] thr);
        longint unsigned d;
        longint unsigned th;
        longint unsigned ratio;
        longint unsigned z;
        longint unsigned n;
        longint unsigned y;
        longint unsigned t;
        longint unsigned sh;
        d  = 64'(dist_in);
        th = 64'(thr);
        // A zero threshold behaves as the smallest step.
        if (th == 0) th = 1;
        if (d >= th) return 64'(FULL_SCALE);
        ratio = (((th - d) << 30) + (th >> 1)) / th;
        z = (ratio * LN1000_FIX + (UNITY_FIX >> 1)) >> 30;
        n = z / LN2_FIX;
        y = z - n * LN2_FIX;
        // exp(-y) by a Horner series, then the power of two from the ln(2) reduction.
        t = UNITY_FIX;
        for (int k = EXP_TERMS; k >= 1; k--) begin
            t = UNITY_FIX - (((y * t) >> 30) / longint'(k));
        end
        sh = 30 - SCALE_FRAC_BITS + n;
        return (t + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic logic [SCALE_WIDTH-1:0] predict_scale(input t_report rep);
        longint unsigned s_self;
        longint unsigned s_scene;
        if (!cfg_check_enable) return FULL_SCALE;
        if (rep.self_hit || rep.scene_hit) return '0;
        s_self  = proximity_term(rep.self_dist, cfg_self_thr);
        s_scene = proximity_term(rep.scene_dist, cfg_scene_thr);
        return SCALE_WIDTH'(s_self < s_scene ? s_self : s_scene);
    endfunction

    // Driver: presents queued reports and predicts the scale of each accepted item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_scales.push_back(predict_scale(driven_report));
                reports_sent++;
            end
            if (!i_valid || o_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_valid <= 1'b0;
                end else if (pending_reports.size() > 0) begin
                    driven_report = pending_reports.pop_front();
                    i_self_hit       <= driven_report.self_hit;
                    i_scene_hit      <= driven_report.scene_hit;
                    i_self_distance  <= driven_report.self_dist;
                    i_scene_distance <= driven_report.scene_dist;
                    i_valid          <= 1'b1;
                    send_wait = send_idle_on ? $urandom_range(0, 9) : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted scale with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_scales.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: unexpected scale %0d at %0t", o_velocity_scale, $realtime);
                end else begin
                    logic [SCALE_WIDTH-1:0] want;
                    want = expected_scales.pop_front();
                    if (o_velocity_scale !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("ERROR: scale %0d expected %0d at %0t",
                                     o_velocity_scale, want, $realtime);
                    end
                end
                scales_checked++;
                recv_wait = recv_idle_on ? $urandom_range(0, 9) : 0;
            end
            // A long hold-off lets the pipeline fill and push back on the input.
            if (long_hold_cycles > 0) begin
                long_hold_cycles--;
                i_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send_report(input logic self_hit, input logic scene_hit,
                               input logic [DIST_WIDTH-1:0] self_dist,
                               input logic [DIST_WIDTH-1:0] scene_dist);
        t_report rep;
        rep.self_hit   = self_hit;
        rep.scene_hit  = scene_hit;
        rep.self_dist  = self_dist;
        rep.scene_dist = scene_dist;
        pending_reports.push_back(rep);
    endtask

    // Waits until every report has gone in and every scale has come out.
    task automatic wait_drained();
        while (pending_reports.size() > 0 || i_valid || expected_scales.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                             input logic [DIST_WIDTH-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_CHECK_ENABLE:    cfg_check_enable = data[0];
            CFG_SELF_THRESHOLD:  cfg_self_thr = data;
            CFG_SCENE_THRESHOLD: cfg_scene_thr = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    // Threshold picks lean toward the extremes.
    function automatic logic [DIST_WIDTH-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0: return DIST_WIDTH'($urandom_range(1, 255));
            1: return DIST_WIDTH'($urandom);
            2: return DIST_WIDTH'(1);
            3: return DIST_MAX;
            4: return '0;
            default: return DIST_WIDTH'($urandom_range(1000, 100000));
        endcase
    endfunction

    // Distances mostly fall below the threshold, where the scale is computed.
    function automatic logic [DIST_WIDTH-1:0] pick_distance(input logic [DIST_WIDTH-1:0] thr);
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return DIST_WIDTH'($urandom_range(0, thr));
            4: return thr + DIST_WIDTH'($urandom_range(0, 2)) - DIST_WIDTH'(1);
            5: return '0;
            6: return DIST_WIDTH'($urandom);
            default: return DIST_WIDTH'($urandom_range(thr, DIST_MAX));
        endcase
    endfunction

    // Stimulus: directed reports, then random phases under changing settings.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset thresholds: hits, boundaries and extreme distances.
        send_report(1'b0, 1'b0, '0, '0);
        send_report(1'b1, 1'b0, '0, '0);
        send_report(1'b0, 1'b1, DIST_MAX, DIST_MAX);
        send_report(1'b1, 1'b1, DIST_MAX, '0);
        send_report(1'b0, 1'b0, SELF_THRESHOLD_RESET, SCENE_THRESHOLD_RESET);
        send_report(1'b0, 1'b0, DIST_WIDTH'(SELF_THRESHOLD_RESET - 1),
                    DIST_WIDTH'(SCENE_THRESHOLD_RESET - 1));
        send_report(1'b0, 1'b0, DIST_MAX, DIST_MAX);
        send_report(1'b0, 1'b0, '0, DIST_MAX);
        send_report(1'b0, 1'b0, DIST_MAX, '0);
        send_report(1'b0, 1'b0, DIST_WIDTH'(SELF_THRESHOLD_RESET / 2), SCENE_THRESHOLD_RESET);
        wait_drained();

        // Largest thresholds.
        write_reg(CFG_SELF_THRESHOLD, DIST_MAX);
        write_reg(CFG_SCENE_THRESHOLD, DIST_MAX);
        send_report(1'b0, 1'b0, '0, '0);
        send_report(1'b0, 1'b0, DIST_WIDTH'(DIST_MAX - 1), DIST_WIDTH'(DIST_MAX - 1));
        send_report(1'b0, 1'b0, 24'h800000, 24'h7FFFFF);
        wait_drained();

        // Zero thresholds act as a threshold of one.
        write_reg(CFG_SELF_THRESHOLD, '0);
        write_reg(CFG_SCENE_THRESHOLD, '0);
        send_report(1'b0, 1'b0, '0, '0);
        send_report(1'b0, 1'b0, 24'd1, '0);
        wait_drained();

        // Checking disabled overrides the hit flags.
        write_reg(CFG_CHECK_ENABLE, '0);
        send_report(1'b1, 1'b1, '0, '0);
        send_report(1'b0, 1'b0, '0, '0);
        send_report(1'b1, 1'b0, DIST_MAX, '0);
        wait_drained();

        // A write to the unused index changes nothing.
        write_reg(CFG_INDEX_UNUSED, DIST_MAX);
        send_report(1'b0, 1'b0, '0, '0);
        send_report(1'b0, 1'b1, 24'd5, 24'd5);
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            logic [DIST_WIDTH-1:0] en_data;
            en_data = DIST_WIDTH'($urandom);
            en_data[0] = (phase != 3);
            write_reg(CFG_CHECK_ENABLE, en_data);
            write_reg(CFG_SELF_THRESHOLD, pick_threshold());
            write_reg(CFG_SCENE_THRESHOLD, pick_threshold());
            if (phase == 5)
                write_reg(CFG_INDEX_UNUSED, DIST_WIDTH'($urandom));

            // Idle patterns vary by phase; phase 0 runs back to back.
            send_idle_on = (phase != 0) && (phase != 2) && ($urandom_range(0, 3) != 0);
            recv_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            if (phase == 2)
                long_hold_cycles = 400;

            for (int n = 0; n < 125; n++) begin
                send_report($urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                            pick_distance(cfg_self_thr), pick_distance(cfg_scene_thr));
            end
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        if (expected_scales.size() != 0) begin
            $display("ERROR: %0d scales never arrived", expected_scales.size());
            mismatch_count += expected_scales.size();
        end
        $display("Sent %0d collision reports and checked %0d scales across %0d register writes,",
                 reports_sent, scales_checked, reg_writes);
        $display("covering hits, disabled checking, zero and full thresholds and output stalls.");
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("Timeout: %0d scales still expected", expected_scales.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
